>>> rtl/core/sbdt_pkg.sv
// Shared types and constants for the signed binary to decimal text converter.
// Holds the control state encoding, the digit cell control group and ASCII codes.
// No dependencies.
package sbdt_pkg;

   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int DIGIT_W  = 4;   // one BCD digit per cell
   localparam int CHAR_W   = 8;
   localparam int LENGTH_W = 4;

   localparam int RADIX = 10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;  // '-'

   // shift-and-add-3: a digit at or above half the radix is corrected before doubling
   localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(RADIX / 2);
   localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'((1 << (DIGIT_W - 1)) - RADIX / 2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;        // zero every digit
      logic bit_shift;    // double-dabble step: take one binary bit
      logic digit_shift;  // move every digit one cell toward the top
   } cell_ctl_type;

endpackage

>>> rtl/core/sbdt_cell.sv
// One BCD digit cell of the conversion chain.
// Depends on sbdt_pkg for the digit width, correction constants and control group.
// Takes a bit or a whole digit from its lower neighbor each cycle it is told to.
module sbdt_cell
   import sbdt_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               shift_bit,
   input  logic [DIGIT_W-1:0] shift_digit,
   output logic               carry_out,
   output logic [DIGIT_W-1:0] digit_out
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adjusted;

   always_comb begin
      adjusted = (digit_ff >= ADJ_LIMIT) ? DIGIT_W'(digit_ff + ADJ_ADD) : digit_ff;
   end

   always_comb begin
      priority if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.bit_shift) begin
         digit_in = {adjusted[DIGIT_W-2:0], shift_bit};
      end else if (ctl.digit_shift) begin
         digit_in = shift_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adjusted[DIGIT_W-1];
   assign digit_out = digit_ff;

endmodule

>>> rtl/core/signed_binary_to_decimal_text.sv
// Top level of the signed binary to decimal text converter.
// Depends on sbdt_pkg and sbdt_cell; builds the BCD cell chain and its controller.
//
// Usage:
//   req_ channel: one transaction carries a signed VALUE_BITS-bit integer (req_value).
//   A new request is taken only while the converter is idle; req_stall is high
//   otherwise.
//   rsp_ channel: one transaction per ASCII character, most significant first:
//   an optional '-', then the digits without leading zeros ("0" for zero).
//   Each character carries the full text length (rsp_text_length, modulo 16)
//   and rsp_last_char marks the final one.
// Steps per request:
//   shift-and-add-3 through the digit chain, one magnitude bit at a time for
//   all VALUE_BITS bits (32 by default), then a trim step that shifts out each
//   suppressed leading zero, then an optional '-' and the digits, each character
//   waiting while the receiver stalls. A new request is taken only after the
//   last character has gone into the output register and the converter is idle.
// Reset: synchronous and active high; the controller returns to idle, any
//   pending response is dropped and req_stall stays high while reset is held.
// Stall: a stalled response holds in the output register; in the sign and emit
//   states the controller waits and the digit chain holds until the character is taken.
module signed_binary_to_decimal_text
   import sbdt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CHAR_W-1:0]            rsp_character,
   output logic [LENGTH_W-1:0]          rsp_text_length,
   output logic                         rsp_last_char
);

   // decimal digits of the largest magnitude 2^(VALUE_BITS-1); 0.30103 ~ log10(2)
   localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int CNT_W  = $clog2(DIGITS + 1);
   localparam int BIT_W  = $clog2(VALUE_BITS);
   localparam int LEN_W  = (CNT_W + 1 > LENGTH_W) ? CNT_W + 1 : LENGTH_W;

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [BIT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [LENGTH_W-1:0]   len_ff, len_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic [LENGTH_W-1:0]   rsp_len_ff, rsp_len_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctl_type          cell_ctl;
   logic [DIGIT_W-1:0]    digit_q [DIGITS];
   logic                  carry   [DIGITS];
   logic [DIGIT_W-1:0]    top_digit;

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  req_accept;
   logic                  out_free;
   logic                  out_load;
   logic [CHAR_W-1:0]     out_char;
   logic                  out_last;
   logic                  trim_skip;
   logic                  dec_rem;
   logic [LEN_W-1:0]      total;

   // ---------------- digit chain ----------------
   // Cell 0 takes the next magnitude bit; each cell feeds its carry and digit upward.
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         sbdt_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl),
            .shift_bit   (mag_ff[VALUE_BITS-1]),
            .shift_digit ('0),
            .carry_out   (carry[i]),
            .digit_out   (digit_q[i])
         );
      end else begin : g_next
         sbdt_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl),
            .shift_bit   (carry[i-1]),
            .shift_digit (digit_q[i-1]),
            .carry_out   (carry[i]),
            .digit_out   (digit_q[i])
         );
      end
   end

   assign top_digit = digit_q[DIGITS-1];

   // ---------------- input side ----------------
   assign raw       = req_value;
   assign magnitude = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + VALUE_BITS'(1)) : raw;
   assign req_accept = req_valid && !req_stall;

   // output register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // drop a leading zero unless it is the only digit left
   assign trim_skip = (top_digit == '0) && (rem_ff != CNT_W'(1));
   assign total     = LEN_W'(rem_ff) + LEN_W'(neg_ff);

   // ---------------- controller: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = ST_TRIM;
         end
         ST_TRIM: begin
            if (!trim_skip) state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && rem_ff == CNT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- controller: outputs ----------------
   always_comb begin
      req_stall = 1'b1;
      cell_ctl  = '0;
      out_load  = 1'b0;
      out_char  = CHAR_MINUS;
      out_last  = 1'b0;
      dec_rem   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall      = reset;
            cell_ctl.clear = req_valid;
         end
         ST_CONVERT: begin
            cell_ctl.bit_shift = 1'b1;
         end
         ST_TRIM: begin
            cell_ctl.digit_shift = trim_skip;
            dec_rem              = trim_skip;
         end
         ST_SIGN: begin
            out_load = out_free;
         end
         ST_EMIT: begin
            out_load             = out_free;
            out_char             = CHAR_ZERO + CHAR_W'(top_digit);
            out_last             = (rem_ff == CNT_W'(1));
            cell_ctl.digit_shift = out_free;
            dec_rem              = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      rem_in     = rem_ff;
      len_in     = len_ff;
      if (req_accept) begin
         mag_in     = magnitude;
         neg_in     = raw[VALUE_BITS-1];
         bit_cnt_in = BIT_W'(VALUE_BITS - 1);
      end else if (state_ff == ST_CONVERT) begin
         mag_in     = mag_ff << 1;
         bit_cnt_in = bit_cnt_ff - BIT_W'(1);
         rem_in     = CNT_W'(DIGITS);
      end else if (dec_rem) begin
         rem_in = rem_ff - CNT_W'(1);
      end
      // text length is fixed once the leading zeros are gone
      if (state_ff == ST_TRIM && !trim_skip) begin
         len_in = total[LENGTH_W-1:0];
      end
   end

   // output register: loads a character, else drains when taken
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_last_in = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_len_in   = len_ff;
         rsp_last_in  = out_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bit_cnt_ff  <= bit_cnt_in;
      rem_ff      <= rem_in;
      len_ff      <= len_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_character   = rsp_char_ff;
   assign rsp_text_length = rsp_len_ff;
   assign rsp_last_char   = rsp_last_ff;

endmodule
